/* src/b32_pkg.sv */
`default_nettype none

package b32_pkg;

  localparam int unsigned ByteWidth    = 8;
  localparam int unsigned GroupWidth   = 5;
  localparam int unsigned SymbolWidth  = 8;
  localparam int unsigned ResidueWidth = 4;
  localparam int unsigned CountWidth   = 3;
  localparam int unsigned MaxSymbols   = 3;
  localparam int unsigned LetterCount  = 26;

  localparam logic [SymbolWidth-1:0] LetterBase = 8'h41;  // 'A'
  localparam logic [SymbolWidth-1:0] DigitBase  = 8'h31;  // '1'

  // Symbols produced by one input byte, oldest in slot 0
  typedef struct packed {
    logic [1:0]                             count;
    logic                                   last;
    logic [MaxSymbols-1:0][SymbolWidth-1:0] sym;
  } pack_result_t;

  // Map a 5-bit group to its alphabet character
  function automatic logic [SymbolWidth-1:0] map_symbol(input logic [GroupWidth-1:0] v);
    logic [SymbolWidth-1:0] wide;
    wide = {{(SymbolWidth-GroupWidth){1'b0}}, v};
    if (wide < SymbolWidth'(LetterCount)) begin
      map_symbol = LetterBase + wide;
    end else begin
      map_symbol = DigitBase + (wide - SymbolWidth'(LetterCount));
    end
  endfunction

endpackage

`default_nettype wire

/* src/base32_stream_encoder_unit.sv */
`default_nettype none

// Channel   Signals                                 Direction
// data      data_valid data_ready data_byte last_byte   in
// symbol    symbol_valid symbol_ready symbol last_symbol out
//
// Each byte yields one or two symbols, up to three on a flush; the symbol
// queue sends one per cycle unless stalled and reloads when empty or as
// its last symbol goes. A byte passes through the input register before
// its symbols appear. Reset (synchronous) clears leftover bits and both
// stages. A stalled symbol channel holds the queue; the input register
// still takes one byte that waits for the queue to drain.

module base32_stream_encoder_unit (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                data_valid,
  output logic                               data_ready,
  input  wire  [b32_pkg::ByteWidth-1:0]      data_byte,
  input  wire                                last_byte,
  output logic                               symbol_valid,
  input  wire                                symbol_ready,
  output logic [b32_pkg::SymbolWidth-1:0]    symbol,
  output logic                               last_symbol
);

  logic                            held_valid;
  logic [b32_pkg::ByteWidth-1:0]   held_byte;
  logic                            held_last;
  logic                            can_load;
  logic                            load;
  b32_pkg::pack_result_t           pack;

  assign load       = held_valid && can_load;
  assign data_ready = !held_valid || load;

  // Hold the accepted item until the queue can take its symbols
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (data_valid && data_ready) begin
      held_valid <= 1'b1;
    end else if (load) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (data_valid && data_ready) begin
      held_byte <= data_byte;
      held_last <= last_byte;
    end
  end

  b32_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .data_byte (held_byte),
    .last_byte (held_last),
    .fire      (load),
    .result    (pack)
  );

  b32_symbol_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .pack         (pack),
    .can_load     (can_load),
    .symbol_valid (symbol_valid),
    .symbol_ready (symbol_ready),
    .symbol       (symbol),
    .last_symbol  (last_symbol)
  );

endmodule

`default_nettype wire

/* src/b32_pack.sv */
`default_nettype none

module b32_pack (
  input  wire                                clk,
  input  wire                                rst,
  input  wire  [b32_pkg::ByteWidth-1:0]      data_byte,
  input  wire                                last_byte,
  input  wire                                fire,
  output b32_pkg::pack_result_t              result
);

  logic [b32_pkg::ResidueWidth-1:0] residue_bits;
  logic [b32_pkg::CountWidth-1:0]   residue_count;
  logic [b32_pkg::ResidueWidth-1:0] residue_bits_next;
  logic [b32_pkg::CountWidth-1:0]   residue_count_next;

  logic [b32_pkg::GroupWidth-1:0]   g0;
  logic [b32_pkg::GroupWidth-1:0]   g1;
  logic [b32_pkg::GroupWidth-1:0]   gflush;
  logic [1:0]                       full_groups;

  // Split leftover bits plus the new byte into full groups and new leftover
  always_comb begin
    g0                 = '0;
    g1                 = '0;
    gflush             = '0;
    full_groups        = 2'd1;
    residue_bits_next  = '0;
    residue_count_next = '0;
    case (residue_count)
      3'd0: begin
        g0                 = data_byte[7:3];
        residue_bits_next  = {1'b0, data_byte[2:0]};
        residue_count_next = 3'd3;
        gflush             = {data_byte[2:0], 2'b00};
      end
      3'd1: begin
        g0                 = {residue_bits[0], data_byte[7:4]};
        residue_bits_next  = data_byte[3:0];
        residue_count_next = 3'd4;
        gflush             = {data_byte[3:0], 1'b0};
      end
      3'd2: begin
        full_groups        = 2'd2;
        g0                 = {residue_bits[1:0], data_byte[7:5]};
        g1                 = data_byte[4:0];
      end
      3'd3: begin
        full_groups        = 2'd2;
        g0                 = {residue_bits[2:0], data_byte[7:6]};
        g1                 = data_byte[5:1];
        residue_bits_next  = {3'b000, data_byte[0]};
        residue_count_next = 3'd1;
        gflush             = {data_byte[0], 4'b0000};
      end
      default: begin
        full_groups        = 2'd2;
        g0                 = {residue_bits[3:0], data_byte[7]};
        g1                 = data_byte[6:2];
        residue_bits_next  = {2'b00, data_byte[1:0]};
        residue_count_next = 3'd2;
        gflush             = {data_byte[1:0], 3'b000};
      end
    endcase
  end

  // Append the padded flush symbol when the last byte leaves bits over
  always_comb begin
    result.sym[0] = b32_pkg::map_symbol(g0);
    result.sym[1] = b32_pkg::map_symbol(g1);
    result.sym[2] = b32_pkg::map_symbol(gflush);
    result.last   = last_byte;
    result.count  = full_groups;
    if (last_byte && (residue_count_next != '0)) begin
      if (full_groups == 2'd1) begin
        result.sym[1] = b32_pkg::map_symbol(gflush);
      end
      result.count = full_groups + 2'd1;
    end
  end

  // Hold leftover bits; clear them at the end of a message
  always_ff @(posedge clk) begin
    if (rst) begin
      residue_bits  <= '0;
      residue_count <= '0;
    end else if (fire) begin
      if (last_byte) begin
        residue_bits  <= '0;
        residue_count <= '0;
      end else begin
        residue_bits  <= residue_bits_next;
        residue_count <= residue_count_next;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_residue_range: assert property (@(posedge clk) disable iff (rst)
    residue_count <= 3'd4)
    else $error("residue count out of range");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    fire && last_byte |=> residue_count == '0)
    else $error("residue not cleared after last item");
`endif

endmodule

`default_nettype wire

/* src/b32_symbol_queue.sv */
`default_nettype none

module b32_symbol_queue (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                load,
  input  b32_pkg::pack_result_t              pack,
  output logic                               can_load,
  output logic                               symbol_valid,
  input  wire                                symbol_ready,
  output logic [b32_pkg::SymbolWidth-1:0]    symbol,
  output logic                               last_symbol
);

  logic [b32_pkg::MaxSymbols-1:0][b32_pkg::SymbolWidth-1:0] slot;
  logic [1:0]                                               count;
  logic                                                     msg_last;
  logic                                                     pop;

  assign symbol_valid = (count != 2'd0);
  assign pop          = symbol_valid && symbol_ready;
  assign can_load     = (count == 2'd0) || ((count == 2'd1) && symbol_ready);
  assign symbol       = slot[0];
  assign last_symbol  = msg_last && (count == 2'd1);

  // Load a fresh group of symbols or advance the head on each taken item
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (load) begin
      count <= pack.count;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot     <= pack.sym;
      msg_last <= pack.last;
    end else if (pop) begin
      slot[0] <= slot[1];
      slot[1] <= slot[2];
    end
  end

`ifndef NO_ASSERTIONS
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> ((count == 2'd0) || ((count == 2'd1) && symbol_ready)))
    else $error("queue overwritten while holding symbols");

  a_shift_order: assert property (@(posedge clk) disable iff (rst)
    pop && !load && (count > 2'd1) |=> symbol == $past(slot[1]))
    else $error("symbol order broken");

  a_last_is_final: assert property (@(posedge clk) disable iff (rst)
    last_symbol && symbol_ready |=> !symbol_valid || $past(load))
    else $error("symbols left after last symbol");
`endif

endmodule

`default_nettype wire
